FILE: sv/sse_pkg.sv
// Shared types and constants for the sleep-state energy block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sse_pkg;

  localparam int MaxStates = 16;
  localparam int StateIdxW = $clog2(MaxStates);
  localparam int CountW    = 5;
  localparam int PowerW    = 16;
  localparam int TransW    = 32;
  localparam int TimeW     = 32;
  localparam int ProdW     = TimeW + PowerW;
  localparam int CostW     = ProdW + 1;
  localparam int SumW      = 63;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam int AddrW   = 3;
  localparam int DataW   = 32;
  localparam logic RegStateCount = 1'b0;

  typedef enum logic {
    ActLoad = 1'b0,
    ActTask = 1'b1
  } action_e;

  typedef struct packed {
    action_e                kind;
    logic [StateIdxW-1:0]   index;
    logic [PowerW-1:0]      power;
    logic [TransW-1:0]      trans;
    logic [TimeW-1:0]       gap;
    logic [TimeW-1:0]       busy;
    logic                   first;
    logic                   last;
  } queue_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkScan,
    BkDrain,
    BkAddGap,
    BkBusyMul,
    BkBusyAdd,
    BkEmit
  } back_state_e;

endpackage

FILE: sv/sleep_state_energy_min.sv
// Sleep-state energy block.
//
// Input channel (in_valid_i / in_stall_o): one beat is either a load of one
// power-state entry (action_i = 0) or a task record (action_i = 1). Output
// channel (out_valid_o / out_stall_i): one beat with total_energy_o and
// saturated_o for every task marked last_task_i; other beats give no result.
// The APB port holds state_count at byte address 0.
//
// A small queue sits between the front end, which takes beats and works out
// the busy and idle spans, and the back end, which carries them out. A load
// beat is written to the table from the idle step. A task scans the n states
// in use, one table entry per cycle through the shared multiplier, then takes
// the minimum, adds the idle cost to the sum, forms the busy-time product and
// adds it; the first task of a schedule skips the scan, the minimum and the
// idle add. A last task then loads the result register in its emit step.
// While the receiver stalls, the result holds and the back end waits in its
// emit step; the queue keeps taking beats until it is full.
// Reset clears the sum and the previous deadline and sets state_count to 1;
// the state table holds no defined value until loaded.
module sleep_state_energy_min (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sse_pkg::AddrW-1:0]     paddr,
  input  logic [sse_pkg::DataW-1:0]     pwdata,
  output logic [sse_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [sse_pkg::StateIdxW-1:0] state_index_i,
  input  logic [sse_pkg::PowerW-1:0]    state_power_i,
  input  logic [sse_pkg::TransW-1:0]    state_transition_i,
  input  logic [sse_pkg::TimeW-1:0]     release_time_i,
  input  logic [sse_pkg::TimeW-1:0]     deadline_time_i,
  input  logic                          last_task_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sse_pkg::SumW-1:0]      total_energy_o,
  output logic                          saturated_o
);
  import sse_pkg::*;

  logic [CountW-1:0] state_count_q;
  logic              cfg_we;
  logic              push, pop;
  queue_entry_t      push_entry, head;
  queue_status_t     q_status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == RegStateCount);
  assign prdata = (paddr[2] == RegStateCount) ? DataW'(state_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q <= CountW'(1);
    end else if (cfg_we) begin
      state_count_q <= pwdata[CountW-1:0];
    end
  end

  sse_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .state_index_i      (state_index_i),
    .state_power_i      (state_power_i),
    .state_transition_i (state_transition_i),
    .release_time_i     (release_time_i),
    .deadline_time_i    (deadline_time_i),
    .last_task_i        (last_task_i),
    .q_status_i         (q_status),
    .push_o             (push),
    .push_entry_o       (push_entry)
  );

  sse_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  sse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .state_count_i  (state_count_q),
    .head_i         (head),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .total_energy_o (total_energy_o),
    .saturated_o    (saturated_o)
  );

endmodule

FILE: sv/sse_front.sv
// Front end: accepts input beats, computes busy and idle spans of task records.
// Depends on sse_pkg; feeds sse_queue.
module sse_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [sse_pkg::StateIdxW-1:0] state_index_i,
  input  logic [sse_pkg::PowerW-1:0]   state_power_i,
  input  logic [sse_pkg::TransW-1:0]   state_transition_i,
  input  logic [sse_pkg::TimeW-1:0]    release_time_i,
  input  logic [sse_pkg::TimeW-1:0]    deadline_time_i,
  input  logic                         last_task_i,
  input  sse_pkg::queue_status_t       q_status_i,
  output logic                         push_o,
  output sse_pkg::queue_entry_t        push_entry_o
);
  import sse_pkg::*;

  logic [TimeW-1:0] prev_dl_q, prev_dl_d;
  logic             first_q, first_d;
  logic             accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept;

  always_comb begin
    push_entry_o.kind  = action_e'(action_i);
    push_entry_o.index = state_index_i;
    push_entry_o.power = state_power_i;
    push_entry_o.trans = state_transition_i;
    // Negative spans count as zero.
    push_entry_o.gap   = (release_time_i > prev_dl_q) ? (release_time_i - prev_dl_q) : '0;
    push_entry_o.busy  = (deadline_time_i > release_time_i) ?
                         (deadline_time_i - release_time_i) : '0;
    push_entry_o.first = first_q;
    push_entry_o.last  = last_task_i;
  end

  always_comb begin
    prev_dl_d = prev_dl_q;
    first_d   = first_q;
    if (accept && action_e'(action_i) == ActTask) begin
      prev_dl_d = deadline_time_i;
      first_d   = last_task_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_dl_q <= '0;
      first_q   <= 1'b1;
    end else begin
      prev_dl_q <= prev_dl_d;
      first_q   <= first_d;
    end
  end

endmodule

FILE: sv/sse_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on sse_pkg for the entry and status types.
module sse_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sse_pkg::queue_entry_t  push_entry_i,
  input  logic                   pop_i,
  output sse_pkg::queue_entry_t  head_o,
  output sse_pkg::queue_status_t status_o
);
  import sse_pkg::*;

  queue_entry_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;

  assign head_o          = mem_q[rd_ptr_q];
  assign status_o.empty  = (cnt_q == '0);
  assign status_o.full   = (cnt_q == QueueCntW'(QueueDepth));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: sv/sse_back.sv
// Back end: holds the power-state table, scans it for the cheapest idle state,
// accumulates the saturating energy sum and drives the result register.
// Depends on sse_pkg; takes entries from sse_queue.
module sse_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sse_pkg::CountW-1:0]   state_count_i,
  input  sse_pkg::queue_entry_t        head_i,
  input  sse_pkg::queue_status_t       q_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sse_pkg::SumW-1:0]     total_energy_o,
  output logic                         saturated_o
);
  import sse_pkg::*;

  logic [PowerW-1:0]    line_power_q [MaxStates];
  logic [TransW-1:0]    line_trans_q [MaxStates];

  back_state_e          state_q, state_d;
  logic [StateIdxW-1:0] cnt_q;
  logic [StateIdxW-1:0] last_idx_q, last_idx;
  logic [TimeW-1:0]     gap_q, busy_q;
  logic                 last_q;
  logic [ProdW-1:0]     prod_q;
  logic [TransW-1:0]    tr_q;
  logic                 pv_q;
  logic [CostW-1:0]     best_q, cost;
  logic [SumW-1:0]      sum_q;
  logic                 clip_q;
  logic                 out_valid_q;
  logic [SumW-1:0]      out_sum_q;
  logic                 out_sat_q;

  // Controls from the output decode.
  logic                 take_task, tbl_we, do_scan, do_busy_mul, do_add, do_emit;
  logic                 out_free;
  logic [CostW-1:0]     add_term;
  logic [SumW:0]        sum_ext;

  assign out_free = !out_valid_q || !out_stall_i;

  // Number of states in use, minus one, with zero as one and above 16 as 16.
  always_comb begin
    if (state_count_i == '0) begin
      last_idx = '0;
    end else if (state_count_i > CountW'(MaxStates)) begin
      last_idx = StateIdxW'(MaxStates - 1);
    end else begin
      last_idx = StateIdxW'(state_count_i - 1'b1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (!q_status_i.empty && head_i.kind == ActTask) begin
          state_d = head_i.first ? BkBusyMul : BkScan;
        end
      end
      BkScan:    if (cnt_q == last_idx_q) state_d = BkDrain;
      BkDrain:   state_d = BkAddGap;
      BkAddGap:  state_d = BkBusyMul;
      BkBusyMul: state_d = BkBusyAdd;
      BkBusyAdd: state_d = last_q ? BkEmit : BkIdle;
      BkEmit:    if (out_free) state_d = BkIdle;
      default:   state_d = BkIdle;
    endcase
  end

  // Output decode.
  always_comb begin
    pop_o       = 1'b0;
    take_task   = 1'b0;
    tbl_we      = 1'b0;
    do_scan     = 1'b0;
    do_busy_mul = 1'b0;
    do_add      = 1'b0;
    do_emit     = 1'b0;
    case (state_q)
      BkIdle: begin
        pop_o     = !q_status_i.empty;
        tbl_we    = !q_status_i.empty && head_i.kind == ActLoad;
        take_task = !q_status_i.empty && head_i.kind == ActTask;
      end
      BkScan:    do_scan = 1'b1;
      BkAddGap:  do_add = 1'b1;
      BkBusyMul: do_busy_mul = 1'b1;
      BkBusyAdd: do_add = 1'b1;
      BkEmit:    do_emit = out_free;
      default: begin
      end
    endcase
  end

  assign cost     = CostW'(prod_q) + CostW'(tr_q);
  assign add_term = (state_q == BkAddGap) ? best_q : CostW'(prod_q);
  assign sum_ext  = {1'b0, sum_q} + (SumW + 1)'(add_term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_task) begin
        pv_q <= 1'b0;
      end else if (do_scan) begin
        pv_q <= 1'b1;
      end
      if (do_add) begin
        // Both operands stay below 2^63, so a set top bit means overflow.
        if (sum_ext[SumW]) begin
          sum_q  <= '1;
          clip_q <= 1'b1;
        end else begin
          sum_q <= sum_ext[SumW-1:0];
        end
      end else if (do_emit) begin
        sum_q  <= '0;
        clip_q <= 1'b0;
      end
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      line_power_q[head_i.index] <= head_i.power;
      line_trans_q[head_i.index] <= head_i.trans;
    end
    if (take_task) begin
      gap_q      <= head_i.gap;
      busy_q     <= head_i.busy;
      last_q     <= head_i.last;
      last_idx_q <= last_idx;
      cnt_q      <= '0;
      best_q     <= '1;
    end else if (do_scan) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (do_scan) begin
      prod_q <= gap_q * line_power_q[cnt_q];
      tr_q   <= line_trans_q[cnt_q];
    end else if (do_busy_mul) begin
      prod_q <= busy_q * line_power_q[0];
    end
    // The product registered in the previous cycle is folded into the minimum.
    if ((state_q == BkScan || state_q == BkDrain) && pv_q && cost < best_q) begin
      best_q <= cost;
    end
    if (do_emit) begin
      out_sum_q <= sum_q;
      out_sat_q <= clip_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign total_energy_o = out_sum_q;
  assign saturated_o    = out_sat_q;

endmodule

FILE: sv/sse_checker.sv
// Port-level checks for the sleep-state energy block, bound to the top level.
// Depends on sse_pkg for port widths.
module sse_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [sse_pkg::SumW-1:0]      total_energy_o,
  input logic                          saturated_o
);

  // A result beat is held while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(total_energy_o) && $stable(saturated_o))
    else $error("stalled result beat changed");

  // A clipped total always reads as the largest value.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (&total_energy_o))
    else $error("saturated result is not the maximum");

  // The input side can only back up after it has taken a beat.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall without a preceding beat");

endmodule

bind sleep_state_energy_min sse_checker u_sse_checker (.*);
